// ----- rtl/ipdt_pkg.sv -----
package ipdt_pkg;

  // Width in bits of every duration register; durations count ticks.
  localparam int unsigned DurW = 14;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLeaderLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLeaderHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMark       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpaceZero  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpaceOne   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStop       = 3'd5;

  // Reset values of the duration registers.
  localparam logic [DurW-1:0] RstLeaderLow  = 14'd9000;
  localparam logic [DurW-1:0] RstLeaderHigh = 14'd4560;
  localparam logic [DurW-1:0] RstMark       = 14'd500;
  localparam logic [DurW-1:0] RstSpaceZero  = 14'd500;
  localparam logic [DurW-1:0] RstSpaceOne   = 14'd1800;
  localparam logic [DurW-1:0] RstStop       = 14'd560;

  // Input mode codes.
  localparam logic ModeTick  = 1'b0;
  localparam logic ModeOffer = 1'b1;

  // Index of the last data bit of a byte.
  localparam logic [2:0] LastBit = 3'd7;

  typedef struct packed {
    logic [DurW-1:0] leader_low;
    logic [DurW-1:0] leader_high;
    logic [DurW-1:0] mark;
    logic [DurW-1:0] space_zero;
    logic [DurW-1:0] space_one;
    logic [DurW-1:0] stop;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic byte_accepted;
    logic underrun;
    logic frame_done;
  } res_t;

endpackage

// ----- rtl/ir_pulse_distance_transmitter_core.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   mode_i, data_byte_i, last_byte_i
// out      output     out_valid_o/out_stall_i line_level_o, busy_res_o,
//                                             byte_accepted_o, underrun_o, frame_done_o
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// The engine state updates on the input transfer and
// its result lands in the output register on the same edge.
// An item can be taken every cycle while no result is stalled; the result is registered.
// Reset puts the engine idle, restores the default durations and empties the output.
// While a result is stalled, input is held off; it resumes in the cycle it is taken.
module ir_pulse_distance_transmitter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         line_level_o,
  output logic                         busy_res_o,
  output logic                         byte_accepted_o,
  output logic                         underrun_o,
  output logic                         frame_done_o,
  input  logic                         cfg_we_i,
  input  logic [ipdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ipdt_pkg::DurW-1:0]    cfg_data_i
);
  import ipdt_pkg::*;

  cfg_t cfg;
  res_t res, res_q;
  logic in_accept;
  logic out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  ipdt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ipdt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // Output register: loads on every input transfer, holds while stalled.
  assign out_valid_d = in_accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = res_q.line_level;
  assign busy_res_o      = res_q.busy_res;
  assign byte_accepted_o = res_q.byte_accepted;
  assign underrun_o      = res_q.underrun;
  assign frame_done_o    = res_q.frame_done;

endmodule

// ----- rtl/ipdt_cfg_regs.sv -----
module ipdt_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipdt_pkg::DurW-1:0]      cfg_data_i,
  output ipdt_pkg::cfg_t                 cfg_o
);
  import ipdt_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLeaderLow:  cfg_d.leader_low  = cfg_data_i;
        RegLeaderHigh: cfg_d.leader_high = cfg_data_i;
        RegMark:       cfg_d.mark        = cfg_data_i;
        RegSpaceZero:  cfg_d.space_zero  = cfg_data_i;
        RegSpaceOne:   cfg_d.space_one   = cfg_data_i;
        RegStop:       cfg_d.stop        = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low  <= RstLeaderLow;
      cfg_q.leader_high <= RstLeaderHigh;
      cfg_q.mark        <= RstMark;
      cfg_q.space_zero  <= RstSpaceZero;
      cfg_q.space_one   <= RstSpaceOne;
      cfg_q.stop        <= RstStop;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ipdt_engine.sv -----
module ipdt_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           mode_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  ipdt_pkg::cfg_t cfg_i,
  output ipdt_pkg::res_t res_o
);
  import ipdt_pkg::*;

  typedef enum logic [5:0] {
    PhIdle     = 6'b000001,
    PhLeadLow  = 6'b000010,
    PhLeadHigh = 6'b000100,
    PhMark     = 6'b001000,
    PhSpace    = 6'b010000,
    PhStop     = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d, eff_phase;
  logic [DurW-1:0] tick_q, tick_d, eff_tick, tick_inc, dur;
  logic [2:0]      bit_q, bit_d, eff_bit;
  logic [7:0]      shift_q, shift_d, eff_shift;
  logic            last_q, last_d, eff_last;
  logic [7:0]      hold_byte_q, hold_byte_d;
  logic            hold_valid_q, hold_valid_d;
  logic            hold_last_q, hold_last_d;
  logic            eff_level;

  // Effective state: a tick while idle with a byte held starts the leader.
  always_comb begin
    eff_phase = phase_q;
    eff_tick  = tick_q;
    eff_bit   = bit_q;
    eff_shift = shift_q;
    eff_last  = last_q;
    if (mode_i == ModeTick && phase_q == PhIdle && hold_valid_q) begin
      eff_phase = PhLeadLow;
      eff_tick  = '0;
      eff_bit   = '0;
      eff_shift = hold_byte_q;
      eff_last  = hold_last_q;
    end
  end

  // Line level and duration of the phase in progress.
  always_comb begin
    unique case (eff_phase)
      PhLeadLow:  begin eff_level = 1'b0; dur = cfg_i.leader_low;  end
      PhLeadHigh: begin eff_level = 1'b1; dur = cfg_i.leader_high; end
      PhMark:     begin eff_level = 1'b0; dur = cfg_i.mark;        end
      PhSpace: begin
        eff_level = 1'b1;
        dur = eff_shift[eff_bit] ? cfg_i.space_one : cfg_i.space_zero;
      end
      PhStop:     begin eff_level = 1'b0; dur = cfg_i.stop;        end
      default:    begin eff_level = 1'b1; dur = DurW'(1);          end
    endcase
  end

  assign tick_inc = eff_tick + DurW'(1);

  // Next state and result for the item in this transfer.
  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    last_d       = last_q;
    hold_byte_d  = hold_byte_q;
    hold_valid_d = hold_valid_q;
    hold_last_d  = hold_last_q;
    res_o        = '0;

    if (mode_i == ModeOffer) begin
      // Byte offer: fill the holding register if it is free.
      if (!hold_valid_q) begin
        hold_byte_d   = data_byte_i;
        hold_last_d   = last_byte_i;
        hold_valid_d  = 1'b1;
        res_o.byte_accepted = 1'b1;
      end
      res_o.line_level = eff_level;
      res_o.busy_res   = (phase_q != PhIdle);
    end else begin
      // Tick: advance the phase counter.
      phase_d = eff_phase;
      tick_d  = eff_tick;
      bit_d   = eff_bit;
      shift_d = eff_shift;
      last_d  = eff_last;
      if (phase_q == PhIdle && hold_valid_q) begin
        hold_valid_d = 1'b0;
      end
      res_o.line_level = eff_level;
      if (eff_phase != PhIdle) begin
        res_o.busy_res = 1'b1;
        tick_d = tick_inc;
        if (tick_inc >= dur) begin
          tick_d = '0;
          unique case (eff_phase)
            PhLeadLow: phase_d = PhLeadHigh;
            PhLeadHigh: begin
              bit_d   = '0;
              phase_d = PhMark;
            end
            PhMark: phase_d = PhSpace;
            PhSpace: begin
              if (eff_bit < LastBit) begin
                bit_d   = eff_bit + 3'd1;
                phase_d = PhMark;
              end else if (eff_last) begin
                phase_d = PhStop;
              end else if (hold_valid_q) begin
                shift_d      = hold_byte_q;
                last_d       = hold_last_q;
                hold_valid_d = 1'b0;
                bit_d        = '0;
                phase_d      = PhMark;
              end else begin
                res_o.underrun = 1'b1;
                phase_d        = PhStop;
              end
            end
            default: begin
              res_o.frame_done = 1'b1;
              phase_d          = PhIdle;
              bit_d            = '0;
            end
          endcase
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      tick_q       <= '0;
      bit_q        <= '0;
      shift_q      <= '0;
      last_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      hold_last_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      last_q       <= last_d;
      hold_valid_q <= hold_valid_d;
      hold_last_q  <= hold_last_d;
    end
  end

  // Held byte is only read while its valid flag is set.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hold_byte_q <= hold_byte_d;
    end
  end

endmodule

// ----- sim/ir_pulse_distance_transmitter_core_test.sv -----
`timescale 1ns / 100ps

module ir_pulse_distance_transmitter_core_test;
  import ipdt_pkg::*;

  // Register indexes past the last duration register; writes to them are dropped.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam logic [DurW-1:0]    DurMax     = 14'h3FFF;

  typedef enum logic [2:0] {
    PhIdle, PhLeadLow, PhLeadHigh, PhMark, PhSpace, PhStop
  } tx_phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } tx_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i = ModeTick;
  logic [7:0]           data_byte_i = '0;
  logic                 last_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 line_level_o;
  logic                 busy_res_o;
  logic                 byte_accepted_o;
  logic                 underrun_o;
  logic                 frame_done_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = RegLeaderLow;
  logic [DurW-1:0]      cfg_data_i = '0;

  ir_pulse_distance_transmitter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_level_o    (line_level_o),
    .busy_res_o      (busy_res_o),
    .byte_accepted_o (byte_accepted_o),
    .underrun_o      (underrun_o),
    .frame_done_o    (frame_done_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus waiting to be sent and line results waiting to come back.
  tx_item_t pending_items[$];
  res_t     due_results[$];
  int       planned_items = 0;
  int       err_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  // Shadow copy of the transmitter state and its duration registers.
  cfg_t       tx_cfg;
  tx_phase_e  tx_phase;
  logic [DurW-1:0] tx_ticks;
  logic [2:0] tx_bit;
  logic [7:0] tx_shift;
  logic       tx_cur_last;
  logic [7:0] tx_hold_byte;
  logic       tx_hold_valid;
  logic       tx_hold_last;

  function automatic logic line_high(tx_phase_e ph);
    return !(ph == PhLeadLow || ph == PhMark || ph == PhStop);
  endfunction

  function automatic void load_held();
    tx_shift = tx_hold_byte;
    tx_cur_last = tx_hold_last;
    tx_hold_valid = 1'b0;
    tx_bit = '0;
  endfunction

  // Advance the shadow transmitter by one tick or offer and return its line result.
  function automatic res_t transmit_step(tx_item_t it);
    res_t r;
    logic [DurW-1:0] span;
    r = '0;
    if (it.mode == ModeOffer) begin
      if (!tx_hold_valid) begin
        tx_hold_byte = it.data;
        tx_hold_last = it.last;
        tx_hold_valid = 1'b1;
        r.byte_accepted = 1'b1;
      end
      r.line_level = line_high(tx_phase);
      r.busy_res = (tx_phase != PhIdle);
    end else begin
      // A waiting byte starts a frame on this very tick.
      if (tx_phase == PhIdle && tx_hold_valid) begin
        load_held();
        tx_phase = PhLeadLow;
        tx_ticks = '0;
      end
      r.line_level = line_high(tx_phase);
      if (tx_phase != PhIdle) begin
        case (tx_phase)
          PhLeadLow:  span = tx_cfg.leader_low;
          PhLeadHigh: span = tx_cfg.leader_high;
          PhMark:     span = tx_cfg.mark;
          PhSpace:    span = tx_shift[tx_bit] ? tx_cfg.space_one : tx_cfg.space_zero;
          default:    span = tx_cfg.stop;
        endcase
        r.busy_res = 1'b1;
        tx_ticks = tx_ticks + 1'b1;
        if (tx_ticks >= span) begin
          tx_ticks = '0;
          case (tx_phase)
            PhLeadLow: tx_phase = PhLeadHigh;
            PhLeadHigh: begin
              tx_bit = '0;
              tx_phase = PhMark;
            end
            PhMark: tx_phase = PhSpace;
            PhSpace: begin
              if (tx_bit != LastBit) begin
                tx_bit = tx_bit + 1'b1;
                tx_phase = PhMark;
              end else if (tx_cur_last) begin
                tx_phase = PhStop;
              end else if (tx_hold_valid) begin
                load_held();
                tx_phase = PhMark;
              end else begin
                r.underrun = 1'b1;
                tx_phase = PhStop;
              end
            end
            default: begin
              r.frame_done = 1'b1;
              tx_phase = PhIdle;
              tx_bit = '0;
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  // Ticks that a phase of the given duration really lasts.
  function automatic int ticks_of(logic [DurW-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic int lead_ticks();
    return ticks_of(tx_cfg.leader_low) + ticks_of(tx_cfg.leader_high);
  endfunction

  function automatic int byte_ticks(logic [7:0] b);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) begin
      n += ticks_of(tx_cfg.mark) + ticks_of(b[i] ? tx_cfg.space_one : tx_cfg.space_zero);
    end
    return n;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_tick(int n);
    tx_item_t it;
    for (int i = 0; i < n; i++) begin
      it.mode = ModeTick;
      it.data = 8'($urandom);
      it.last = 1'($urandom);
      pending_items.push_back(it);
      planned_items++;
    end
  endtask

  task automatic push_offer(logic [7:0] b, logic last);
    tx_item_t it;
    it.mode = ModeOffer;
    it.data = b;
    it.last = last;
    pending_items.push_back(it);
    planned_items++;
  endtask

  // A frame of one or more bytes, each next byte offered at a random point while the
  // holding register is free. Sometimes a byte comes too late or the last flag
  // is never set, so the frame runs dry.
  task automatic queue_frame(int nbytes, bit starve);
    logic [7:0] cur;
    logic [7:0] nxt;
    int span;
    int at;
    bit late;
    cur = pick_byte();
    push_offer(cur, (nbytes == 1) && !starve);
    push_tick(1);
    span = lead_ticks() - 1 + byte_ticks(cur);
    late = 1'b0;
    for (int k = 1; k < nbytes && !late; k++) begin
      nxt = pick_byte();
      late = ($urandom_range(0, 99) < 10);
      at = late ? span : $urandom_range(0, span - 1);
      push_tick(at);
      push_offer(nxt, (k == nbytes - 1) && !starve);
      push_tick(span - at);
      span = byte_ticks(nxt);
    end
    if (!late) push_tick(span);
    // A byte offered during the stop pulse waits for the next frame.
    if ($urandom_range(0, 99) < 15) push_offer(pick_byte(), 1'($urandom));
    push_tick(ticks_of(tx_cfg.stop) + $urandom_range(0, 3));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLeaderLow:  tx_cfg.leader_low = val;
      RegLeaderHigh: tx_cfg.leader_high = val;
      RegMark:       tx_cfg.mark = val;
      RegSpaceZero:  tx_cfg.space_zero = val;
      RegSpaceOne:   tx_cfg.space_one = val;
      RegStop:       tx_cfg.stop = val;
      default:       ;
    endcase
  endtask

  task automatic program_all(cfg_t c);
    write_reg(RegLeaderLow, c.leader_low);
    write_reg(RegLeaderHigh, c.leader_high);
    write_reg(RegMark, c.mark);
    write_reg(RegSpaceZero, c.space_zero);
    write_reg(RegSpaceOne, c.space_one);
    write_reg(RegStop, c.stop);
  endtask

  task automatic set_idling(int m);
    case (m)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 46; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  // Wait until all queued stimulus is sent and every result has been checked.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Wait until all stimulus is sent and answered, then tick out any open frame.
  task automatic settle();
    bit open;
    open = 1'b1;
    while (open) begin
      drain();
      open = (tx_phase != PhIdle) || tx_hold_valid;
      if (open) push_tick(16);
    end
  endtask

  // Input driver: predicts each transfer and presents the next queued item.
  tx_item_t next_item;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= ModeTick;
      data_byte_i <= '0;
      last_byte_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(transmit_step({mode_i, data_byte_i, last_byte_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= next_item.mode;
          data_byte_i <= next_item.data;
          last_byte_i <= next_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks every result transfer against the oldest prediction.
  res_t got;
  res_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {line_level_o, busy_res_o, byte_accepted_o, underrun_o, frame_done_o};
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("%0t: result with no prediction waiting", $realtime);
        end else begin
          want = due_results.pop_front();
          if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
              got.byte_accepted !== want.byte_accepted || got.underrun !== want.underrun ||
              got.frame_done !== want.frame_done) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: line/busy/taken/underrun/done got %b%b%b%b%b want %b%b%b%b%b",
                       $realtime, got.line_level, got.busy_res, got.byte_accepted,
                       got.underrun, got.frame_done, want.line_level, want.busy_res,
                       want.byte_accepted, want.underrun, want.frame_done);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Test sequence.
  initial begin
    cfg_t c;
    int start;
    tx_cfg = '{RstLeaderLow, RstLeaderHigh, RstMark, RstSpaceZero, RstSpaceOne, RstStop};
    tx_phase = PhIdle;
    tx_ticks = '0;
    tx_bit = '0;
    tx_shift = '0;
    tx_cur_last = 1'b0;
    tx_hold_byte = '0;
    tx_hold_valid = 1'b0;
    tx_hold_last = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Durations after reset: the leader opens with its long low part, then
    // short durations finish the frame.
    set_idling(0);
    push_offer(8'h01, 1'b1);
    push_tick(24);
    drain();
    program_all('{14'd2, 14'd2, 14'd1, 14'd1, 14'd2, 14'd1});
    settle();

    // Zero durations, dropped writes to spare indexes, and the corner cases.
    program_all('{14'd0, 14'd1, 14'd0, 14'd1, 14'd2, 14'd0});
    write_reg(RegSpareLo, DurMax);
    write_reg(RegSpareHi, 14'h2AAA);
    push_tick(1);
    push_offer(8'hFF, 1'b0);
    push_offer(8'h00, 1'b1);      // holding register full: dropped
    push_tick(1);                 // frame starts and frees the holding register
    push_offer(8'h00, 1'b1);
    push_tick(lead_ticks() - 1 + byte_ticks(8'hFF) + 2);
    push_offer(8'h3C, 1'b1);      // waits until the frame is over
    push_tick(byte_ticks(8'h00) - 2 + ticks_of(tx_cfg.stop) + lead_ticks() +
              byte_ticks(8'h3C) + ticks_of(tx_cfg.stop) + 1);
    push_offer(8'h81, 1'b0);      // nothing follows: runs dry
    push_tick(lead_ticks() + byte_ticks(8'h81) + ticks_of(tx_cfg.stop) + 2);
    settle();

    // Random short durations under every idling pattern.
    for (int p = 0; p < 4; p++) begin
      c.leader_low = 14'($urandom_range(1, 4));
      c.leader_high = 14'($urandom_range(1, 4));
      c.mark = 14'($urandom_range(1, 3));
      c.space_zero = 14'($urandom_range(1, 3));
      c.space_one = 14'($urandom_range(1, 5));
      c.stop = 14'($urandom_range(1, 4));
      program_all(c);
      set_idling(p % 4);
      start = planned_items;
      while (planned_items - start < 40) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: queue_frame($urandom_range(1, 3), $urandom_range(0, 99) < 15);
          7, 8: begin
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 1) == 0) push_tick(1);
              else push_offer(8'($urandom), 1'($urandom));
            end
          end
          default: push_tick($urandom_range(1, 6));
        endcase
      end
      settle();
    end

    // Longest leader: the line stays low well past a short run.
    set_idling(0);
    program_all('{DurMax, DurMax, DurMax, 14'd1, 14'd1, DurMax});
    push_offer(8'h5A, 1'b1);
    push_tick(24);
    drain();
    program_all('{14'd1, 14'd2, 14'd1, 14'd1, 14'd2, 14'd1});
    settle();

    // Longest spaces: the first space stays high well past a short run.
    program_all('{14'd1, 14'd1, 14'd1, DurMax, DurMax, 14'd1});
    push_offer(8'hC3, 1'b1);
    push_tick(24);
    drain();
    program_all('{14'd1, 14'd1, 14'd1, 14'd2, 14'd3, 14'd1});
    settle();

    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0) begin
      err_count++;
      if (err_count <= 10) $display("%0d predicted results never arrived", due_results.size());
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(64'd20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ipdt_pkg.sv
rtl/ipdt_cfg_regs.sv
rtl/ipdt_engine.sv
rtl/ir_pulse_distance_transmitter_core.sv
sim/ir_pulse_distance_transmitter_core_test.sv
